FILE: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  // Command modes on the input channel
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_STOP  = 3'd1;
  localparam logic [2:0] MODE_WRITE = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_WAIT  = 3'd4;

  // Operation codes held in the engine state
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic CFG_REG_PHASE_TICKS = 1'b0;
  localparam logic CFG_REG_ACK_TIMEOUT = 1'b1;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_level;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  phase;
    logic [15:0] ticks;
    logic [3:0]  bits;
    logic [7:0]  shift;
    logic [7:0]  tmo;
    logic        scl;
    logic        sda_low;
    logic        ack_flag;
    logic [7:0]  rx;
    logic        ack_choice;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  localparam state_t STATE_RST = '{
    op: OP_IDLE, phase: 2'd0, ticks: 16'd0, bits: 4'd0, shift: 8'd0, tmo: 8'd0,
    scl: 1'b1, sda_low: 1'b0, ack_flag: 1'b0, rx: 8'd0, ack_choice: 1'b0
  };

  // Line levels for the phase the state now sits in; an undriven line keeps its level.
  function automatic state_t drive_lines(input state_t s);
    state_t d;
    d = s;
    case (s.op)
      OP_START: begin
        if (s.phase == 2'd0) begin
          d.sda_low = 1'b0;
        end else if (s.phase == 2'd1) begin
          d.scl = 1'b1; d.sda_low = 1'b0;
        end else if (s.phase == 2'd2) begin
          d.scl = 1'b1; d.sda_low = 1'b1;
        end else begin
          d.scl = 1'b0; d.sda_low = 1'b1;
        end
      end
      OP_STOP: begin
        if (s.phase == 2'd0) begin
          d.scl = 1'b0; d.sda_low = 1'b1;
        end else if (s.phase == 2'd1) begin
          d.scl = 1'b1; d.sda_low = 1'b1;
        end else begin
          d.scl = 1'b1; d.sda_low = 1'b0;
        end
      end
      OP_WRITE: begin
        if (s.bits < 4'd8) begin
          if (s.phase == 2'd0) begin
            d.scl = 1'b0; d.sda_low = ~s.shift[7];
          end else if (s.phase == 2'd1) begin
            d.scl = 1'b1;
          end else begin
            d.scl = 1'b0;
          end
        end else begin
          if (s.phase == 2'd0) begin
            d.sda_low = 1'b0;
          end else begin
            d.scl = 1'b0;
          end
        end
      end
      OP_READ: begin
        if (s.bits < 4'd8) begin
          if (s.phase == 2'd0) begin
            d.scl = 1'b0; d.sda_low = 1'b0;
          end else begin
            d.scl = 1'b1;
          end
        end else begin
          if (s.phase == 2'd0) begin
            d.scl = 1'b0; d.sda_low = s.ack_choice;
          end else if (s.phase == 2'd1) begin
            d.scl = 1'b1;
          end else begin
            d.scl = 1'b0;
          end
        end
      end
      OP_WAIT: begin
        if (s.phase == 2'd0) begin
          d.sda_low = 1'b0;
        end else if (s.phase == 2'd1) begin
          d.scl = 1'b1;
        end else begin
          d.scl = 1'b0;
        end
      end
      default: begin
        d = s;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/i2cm_step.sv
module i2cm_step (
  input  i2cm_pkg::state_t cur,
  input  i2cm_pkg::cmd_t   cmd,
  input  logic [15:0]      phase_ticks,
  input  logic [7:0]       ack_timeout,
  output i2cm_pkg::state_t nxt,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  logic [15:0] limit;
  logic        fin;
  state_t      n;

  assign limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  always_comb begin
    n   = cur;
    fin = 1'b0;
    if (cur.op == OP_IDLE) begin
      if (cmd.cmd_valid && (cmd.mode <= MODE_WAIT)) begin
        n.op    = cmd.mode + 3'd1;
        n.phase = 2'd0;
        n.bits  = 4'd0;
        n.tmo   = 8'd0;
        n.shift = (cmd.mode == MODE_WRITE) ? cmd.tx_byte : 8'd0;
        if (cmd.mode == MODE_READ) begin
          n.ack_choice = cmd.send_ack;
        end
        n.ticks = 16'd1;
        n = drive_lines(n);
      end
    end else if (cur.ticks >= limit) begin
      n.ticks = 16'd1;
      case (cur.op)
        OP_START: begin
          if (cur.phase < 2'd3) n.phase = cur.phase + 2'd1;
          else fin = 1'b1;
        end
        OP_STOP: begin
          if (cur.phase < 2'd2) n.phase = cur.phase + 2'd1;
          else fin = 1'b1;
        end
        OP_WRITE: begin
          if (cur.bits < 4'd8) begin
            if (cur.phase < 2'd2) begin
              n.phase = cur.phase + 2'd1;
            end else begin
              n.shift = {cur.shift[6:0], 1'b0};
              n.bits  = cur.bits + 4'd1;
              n.phase = 2'd0;
            end
          end else if (cur.phase < 2'd1) begin
            n.phase = cur.phase + 2'd1;
          end else begin
            fin = 1'b1;
          end
        end
        OP_READ: begin
          if (cur.bits < 4'd8) begin
            if (cur.phase == 2'd0) begin
              n.phase = 2'd1;
            end else begin
              // sample on the last tick of the SCL-high phase
              n.shift = {cur.shift[6:0], cmd.sda_level};
              n.bits  = cur.bits + 4'd1;
              n.phase = 2'd0;
            end
          end else if (cur.phase < 2'd2) begin
            n.phase = cur.phase + 2'd1;
          end else begin
            n.rx = cur.shift;
            fin  = 1'b1;
          end
        end
        OP_WAIT: begin
          if (cur.phase == 2'd0) begin
            n.phase = 2'd1;
          end else if (cur.phase == 2'd1) begin
            if (!cmd.sda_level) begin
              n.phase = 2'd2;
            end else if (cur.tmo >= ack_timeout) begin
              // timed out: flag it and fall into a stop sequence
              n.ack_flag = 1'b1;
              n.op       = OP_STOP;
              n.phase    = 2'd0;
            end else begin
              n.tmo = cur.tmo + 8'd1;
            end
          end else begin
            n.ack_flag = 1'b0;
            fin        = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
      if (fin) begin
        n.op    = OP_IDLE;
        n.phase = 2'd0;
      end else begin
        n = drive_lines(n);
      end
    end else begin
      n.ticks = cur.ticks + 16'd1;
    end
  end

  assign nxt = n;

  always_comb begin
    res.scl_level    = n.scl;
    res.sda_pull_low = n.sda_low;
    res.busy_res     = (n.op != OP_IDLE);
    res.done_res     = fin;
    res.rx_byte      = n.rx;
    res.ack_missing  = n.ack_flag;
  end

endmodule

FILE: rtl/core/i2cm_skid.sv
module i2cm_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::res_t push_data,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::res_t out_data
);
  import i2cm_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_d_r;
  res_t skid_d_r;
  logic slot_free;

  assign space     = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;
  assign slot_free = ~main_v_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (slot_free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (slot_free) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule

FILE: rtl/core/i2c_master_bit_engine.sv
// I2C master bit engine. Each beat on the input channel is one tick of the bit
// timer: it carries the sampled SDA level and, while the engine is idle, an
// optional command (start, stop, write byte, read byte plus ACK/NACK, wait for
// acknowledge). Every accepted beat yields exactly one result beat with the
// SCL level, the SDA pull-low, busy, a done pulse, the last received byte and
// the acknowledge-missing flag.
// Throughput is one beat per cycle while in_ready is high; the tick's state
// update and its result are computed in one pass from the engine state register.
// A result is registered in the output entry, or in the spare entry while that is full.
// The result side holds two beats. While out_ready is low and the output entry
// is full, one more beat is taken into the spare entry, then in_ready drops; it
// rises again at the edge where the receiver takes a beat.
// Configuration over APB: phase_ticks at 0x0, ack_timeout at 0x4; write only
// while idle. Reset (rst_n low, synchronous) puts the engine idle with SCL
// high, SDA released, both result entries empty and the registers at
// 100 ticks per phase and 250 timeout phases.
module i2c_master_bit_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd_valid,
  input  logic [2:0]                   in_mode,
  input  logic [7:0]                   in_tx_byte,
  input  logic                         in_send_ack,
  input  logic                         in_sda_level,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_scl_level,
  output logic                         out_sda_pull_low,
  output logic                         out_busy_res,
  output logic                         out_done_res,
  output logic [7:0]                   out_rx_byte,
  output logic                         out_ack_missing,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0]  paddr,
  input  logic [i2cm_pkg::CFG_DW-1:0]  pwdata,
  output logic [i2cm_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import i2cm_pkg::*;

  logic [15:0] phase_ticks_r;
  logic [7:0]  ack_timeout_r;
  state_t      state_r;
  state_t      state_nxt;
  cmd_t        cmd;
  res_t        res;
  res_t        out_d;
  logic        in_fire;
  logic        cfg_wr;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel & penable & pwrite;
  assign prdata  = (reg_sel == CFG_REG_ACK_TIMEOUT) ? {{(CFG_DW-8){1'b0}}, ack_timeout_r}
                                                    : {{(CFG_DW-16){1'b0}}, phase_ticks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (reg_sel == CFG_REG_PHASE_TICKS) begin
        phase_ticks_r <= pwdata[15:0];
      end else begin
        ack_timeout_r <= pwdata[7:0];
      end
    end
  end

  assign cmd = '{cmd_valid: in_cmd_valid, mode: in_mode, tx_byte: in_tx_byte,
                 send_ack: in_send_ack, sda_level: in_sda_level};

  assign in_fire = in_valid & in_ready;

  i2cm_step u_step (
    .cur         (state_r),
    .cmd         (cmd),
    .phase_ticks (phase_ticks_r),
    .ack_timeout (ack_timeout_r),
    .nxt         (state_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  i2cm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_d)
  );

  assign out_scl_level    = out_d.scl_level;
  assign out_sda_pull_low = out_d.sda_pull_low;
  assign out_busy_res     = out_d.busy_res;
  assign out_done_res     = out_d.done_res;
  assign out_rx_byte      = out_d.rx_byte;
  assign out_ack_missing  = out_d.ack_missing;

endmodule

FILE: dv/i2c_bit_engine_checker.sv
module i2c_bit_engine_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_cmd_valid,
  input  logic [2:0]                     in_mode,
  input  logic [7:0]                     in_tx_byte,
  input  logic                           in_send_ack,
  input  logic                           in_sda_level,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_scl_level,
  input  logic                           out_sda_pull_low,
  input  logic                           out_busy_res,
  input  logic                           out_done_res,
  input  logic [7:0]                     out_rx_byte,
  input  logic                           out_ack_missing,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cm_pkg::CFG_AW-1:0]    paddr,
  input  logic [i2cm_pkg::CFG_DW-1:0]    pwdata,
  input  logic                           pready,
  output logic                           engine_idle,
  output int unsigned                    pending,
  output int unsigned                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Shadow copy of the registers
  logic [15:0] cfg_phase_ticks;
  logic [7:0]  cfg_ack_timeout;

  // Shadow copy of the engine
  logic [2:0]  eng_op;
  int unsigned eng_phase;
  int unsigned eng_ticks;
  int unsigned eng_bits;
  logic [7:0]  eng_shift;
  int unsigned eng_tmo;
  logic        scl_q;
  logic        sda_low_q;
  logic        ack_missing_q;
  logic [7:0]  rx_q;
  logic        ack_choice_q;

  res_t bus_levels_q[$];

  // Line levels on entry to the current phase; a line not set keeps its level.
  function automatic void apply_phase_levels();
    case (eng_op)
      OP_START: begin
        case (eng_phase)
          0: sda_low_q = 1'b0;
          1: begin
            scl_q = 1'b1;
            sda_low_q = 1'b0;
          end
          2: begin
            scl_q = 1'b1;
            sda_low_q = 1'b1;
          end
          default: begin
            scl_q = 1'b0;
            sda_low_q = 1'b1;
          end
        endcase
      end
      OP_STOP: begin
        case (eng_phase)
          0: begin
            scl_q = 1'b0;
            sda_low_q = 1'b1;
          end
          1: begin
            scl_q = 1'b1;
            sda_low_q = 1'b1;
          end
          default: begin
            scl_q = 1'b1;
            sda_low_q = 1'b0;
          end
        endcase
      end
      OP_WRITE: begin
        if (eng_bits < 8) begin
          if (eng_phase == 0) begin
            scl_q = 1'b0;
            sda_low_q = ~eng_shift[7];
          end else if (eng_phase == 1) begin
            scl_q = 1'b1;
          end else begin
            scl_q = 1'b0;
          end
        end else if (eng_phase == 0) begin
          sda_low_q = 1'b0;
        end else begin
          scl_q = 1'b0;
        end
      end
      OP_READ: begin
        if (eng_bits < 8) begin
          if (eng_phase == 0) begin
            scl_q = 1'b0;
            sda_low_q = 1'b0;
          end else begin
            scl_q = 1'b1;
          end
        end else if (eng_phase == 0) begin
          scl_q = 1'b0;
          sda_low_q = ack_choice_q;
        end else if (eng_phase == 1) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      OP_WAIT: begin
        if (eng_phase == 0) begin
          sda_low_q = 1'b0;
        end else if (eng_phase == 1) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Last tick of a phase: step to the next one, returns 1 when the command is over.
  function automatic bit finish_phase(input logic sda);
    bit last;
    last = 1'b0;
    case (eng_op)
      OP_START: begin
        if (eng_phase < 3) eng_phase++;
        else last = 1'b1;
      end
      OP_STOP: begin
        if (eng_phase < 2) eng_phase++;
        else last = 1'b1;
      end
      OP_WRITE: begin
        if (eng_bits < 8) begin
          if (eng_phase < 2) begin
            eng_phase++;
          end else begin
            eng_shift = eng_shift << 1;
            eng_bits++;
            eng_phase = 0;
          end
        end else if (eng_phase < 1) begin
          eng_phase++;
        end else begin
          last = 1'b1;
        end
      end
      OP_READ: begin
        if (eng_bits < 8) begin
          if (eng_phase == 0) begin
            eng_phase = 1;
          end else begin
            eng_shift = {eng_shift[6:0], sda};
            eng_bits++;
            eng_phase = 0;
          end
        end else if (eng_phase < 2) begin
          eng_phase++;
        end else begin
          rx_q = eng_shift;
          last = 1'b1;
        end
      end
      OP_WAIT: begin
        if (eng_phase == 0) begin
          eng_phase = 1;
        end else if (eng_phase == 1) begin
          if (!sda) begin
            eng_phase = 2;
          end else if (eng_tmo >= cfg_ack_timeout) begin
            // no acknowledge: flag it and fall into a stop condition
            ack_missing_q = 1'b1;
            eng_op = OP_STOP;
            eng_phase = 0;
          end else begin
            eng_tmo++;
          end
        end else begin
          ack_missing_q = 1'b0;
          last = 1'b1;
        end
      end
      default: last = 1'b1;
    endcase
    return last;
  endfunction

  function automatic res_t advance_bit_timer(input cmd_t c);
    res_t r;
    int unsigned span;
    logic done;
    span = (cfg_phase_ticks == 16'd0) ? 1 : int'(cfg_phase_ticks);
    done = 1'b0;
    if (eng_op == OP_IDLE) begin
      if (c.cmd_valid && c.mode <= MODE_WAIT) begin
        case (c.mode)
          MODE_START: eng_op = OP_START;
          MODE_STOP:  eng_op = OP_STOP;
          MODE_WRITE: eng_op = OP_WRITE;
          MODE_READ:  eng_op = OP_READ;
          default:    eng_op = OP_WAIT;
        endcase
        eng_phase = 0;
        eng_bits = 0;
        eng_tmo = 0;
        eng_shift = (c.mode == MODE_WRITE) ? c.tx_byte : 8'd0;
        if (c.mode == MODE_READ) ack_choice_q = c.send_ack;
        eng_ticks = 1;
        apply_phase_levels();
      end
    end else if (eng_ticks >= span) begin
      eng_ticks = 1;
      if (finish_phase(c.sda_level)) begin
        eng_op = OP_IDLE;
        eng_phase = 0;
        done = 1'b1;
      end else begin
        apply_phase_levels();
      end
    end else begin
      eng_ticks++;
    end
    r.scl_level = scl_q;
    r.sda_pull_low = sda_low_q;
    r.busy_res = (eng_op != OP_IDLE);
    r.done_res = done;
    r.rx_byte = rx_q;
    r.ack_missing = ack_missing_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    cmd_t c;
    res_t want;
    if (!rst_n) begin
      cfg_phase_ticks = PHASE_TICKS_RST;
      cfg_ack_timeout = ACK_TIMEOUT_RST;
      eng_op = OP_IDLE;
      eng_phase = 0;
      eng_ticks = 0;
      eng_bits = 0;
      eng_shift = 8'd0;
      eng_tmo = 0;
      scl_q = 1'b1;
      sda_low_q = 1'b0;
      ack_missing_q = 1'b0;
      rx_q = 8'd0;
      ack_choice_q = 1'b0;
      mismatches = 0;
      bus_levels_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if ((paddr >> 2) == CFG_AW'(CFG_REG_PHASE_TICKS)) cfg_phase_ticks = pwdata[15:0];
        else if ((paddr >> 2) == CFG_AW'(CFG_REG_ACK_TIMEOUT)) cfg_ack_timeout = pwdata[7:0];
      end
      // result beat first: it can only belong to an earlier input beat
      if (out_valid && out_ready) begin
        if (bus_levels_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = bus_levels_q.pop_front();
          check_field("scl_level", want.scl_level, out_scl_level);
          check_field("sda_pull_low", want.sda_pull_low, out_sda_pull_low);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("done_res", want.done_res, out_done_res);
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("ack_missing", want.ack_missing, out_ack_missing);
        end
      end
      if (in_valid && in_ready) begin
        c.cmd_valid = in_cmd_valid;
        c.mode = in_mode;
        c.tx_byte = in_tx_byte;
        c.send_ack = in_send_ack;
        c.sda_level = in_sda_level;
        bus_levels_q.push_back(advance_bit_timer(c));
      end
    end
    engine_idle = (eng_op == OP_IDLE);
    pending = bus_levels_q.size();
  end

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam logic [CFG_AW-1:0] ADDR_PHASE_TICKS = CFG_AW'(CFG_REG_PHASE_TICKS) << 2;
  localparam logic [CFG_AW-1:0] ADDR_ACK_TIMEOUT = CFG_AW'(CFG_REG_ACK_TIMEOUT) << 2;

  typedef enum int {SDA_LOW, SDA_HIGH, SDA_RAND, SDA_MOSTLY_HIGH} sda_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd_valid = 1'b0;
  logic [2:0] in_mode = 3'd0;
  logic [7:0] in_tx_byte = 8'd0;
  logic in_send_ack = 1'b0;
  logic in_sda_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_scl_level;
  logic out_sda_pull_low;
  logic out_busy_res;
  logic out_done_res;
  logic [7:0] out_rx_byte;
  logic out_ack_missing;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  logic engine_idle;
  int unsigned pending;
  int unsigned mismatches;

  bit idling_on = 1'b1;
  int unsigned ticks_sent = 0;
  int unsigned beats_taken = 0;
  int unsigned cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  i2c_master_bit_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd_valid(in_cmd_valid), .in_mode(in_mode), .in_tx_byte(in_tx_byte),
    .in_send_ack(in_send_ack), .in_sda_level(in_sda_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_scl_level(out_scl_level), .out_sda_pull_low(out_sda_pull_low),
    .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_rx_byte(out_rx_byte), .out_ack_missing(out_ack_missing),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2c_bit_engine_checker u_bus_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd_valid(in_cmd_valid), .in_mode(in_mode), .in_tx_byte(in_tx_byte),
    .in_send_ack(in_send_ack), .in_sda_level(in_sda_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_scl_level(out_scl_level), .out_sda_pull_low(out_sda_pull_low),
    .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_rx_byte(out_rx_byte), .out_ack_missing(out_ack_missing),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .engine_idle(engine_idle), .pending(pending), .mismatches(mismatches)
  );

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic sda_for(input sda_kind_t kind);
    case (kind)
      SDA_LOW:         return 1'b0;
      SDA_HIGH:        return 1'b1;
      SDA_MOSTLY_HIGH: return ($urandom_range(0, 7) != 0);
      default:         return 1'($urandom_range(0, 1));
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (out_valid && out_ready) beats_taken++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the output buffer
  // fills and in_ready drops while beats keep being offered.
  always @(negedge clk) begin : result_sink
    int unsigned hold_left;
    bit long_hold_done;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && beats_taken >= 200 && in_valid) begin
      long_hold_done = 1'b1;
      hold_left = 299;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      hold_left = gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // All stimulus tasks start and end at a falling edge.
  task automatic send_tick(input logic cv, input logic [2:0] mode, input logic [7:0] tx,
                           input logic ack, input logic sda);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd_valid <= cv;
    in_mode <= mode;
    in_tx_byte <= tx;
    in_send_ack <= ack;
    in_sda_level <= sda;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  // Offer one command on an idle engine and keep ticking until it is idle again.
  // Commands thrown in while busy are noise the engine must ignore.
  task automatic issue_cmd(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                           input sda_kind_t kind);
    logic noisy;
    send_tick(1'b1, mode, tx, ack, sda_for(kind));
    while (!engine_idle) begin
      noisy = ($urandom_range(0, 7) == 0);
      send_tick(noisy, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                sda_for(kind));
    end
  endtask

  // Ticks with no command or with an out-of-range mode; the engine stays idle.
  task automatic idle_ticks(input int unsigned n);
    logic cv;
    repeat (n) begin
      cv = 1'($urandom_range(0, 1));
      send_tick(cv, cv ? 3'($urandom_range(int'(MODE_WAIT) + 1, 7)) : 3'($urandom_range(0, 7)),
                8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !engine_idle);
  endtask

  // Upper data bits carry junk; the registers keep only their own width.
  task automatic set_timing(input logic [15:0] ticks, input logic [7:0] timeout);
    settle();
    write_reg(ADDR_PHASE_TICKS, {16'($urandom), ticks});
    write_reg(ADDR_ACK_TIMEOUT, {24'($urandom), timeout});
  endtask

  task automatic set_idling(input bit on);
    in_valid <= 1'b0;
    @(posedge clk) idling_on = on;
    @(negedge clk);
  endtask

  task automatic write_then_ack();
    issue_cmd(MODE_WRITE, 8'($urandom), 1'($urandom), SDA_RAND);
    issue_cmd(MODE_WAIT, 8'($urandom), 1'($urandom),
              ($urandom_range(0, 4) == 0) ? SDA_MOSTLY_HIGH : SDA_RAND);
  endtask

  // start, address byte, ack, some data bytes either way, last read NACKed, stop
  task automatic random_transaction();
    int unsigned n;
    n = $urandom_range(1, 3);
    issue_cmd(MODE_START, 8'($urandom), 1'($urandom), SDA_RAND);
    write_then_ack();
    repeat (n) begin
      if ($urandom_range(0, 1)) write_then_ack();
      else issue_cmd(MODE_READ, 8'($urandom), 1'b1, SDA_RAND);
    end
    issue_cmd(MODE_READ, 8'($urandom), 1'b0, SDA_RAND);
    issue_cmd(MODE_STOP, 8'($urandom), 1'($urandom), SDA_RAND);
  endtask

  task automatic random_phase(input logic [15:0] ticks, input logic [7:0] timeout,
                              input int unsigned budget);
    int unsigned goal;
    set_timing(ticks, timeout);
    goal = ticks_sent + budget;
    while (ticks_sent < goal) begin
      if ($urandom_range(0, 3) != 0) random_transaction();
      else if ($urandom_range(0, 1)) issue_cmd(3'($urandom_range(0, 7)), 8'($urandom),
                                               1'($urandom), sda_kind_t'($urandom_range(0, 3)));
      else idle_ticks($urandom_range(1, 4));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero phase length runs as one tick; timeout after two polling phases
    set_timing(16'd0, 8'd1);
    for (int m = int'(MODE_WAIT) + 1; m < 8; m++) send_tick(1'b1, 3'(m), 8'hFF, 1'b1, 1'b1);
    issue_cmd(MODE_START, 8'h00, 1'b0, SDA_RAND);
    issue_cmd(MODE_WRITE, 8'h00, 1'b0, SDA_RAND);
    issue_cmd(MODE_WAIT, 8'h00, 1'b0, SDA_LOW);
    issue_cmd(MODE_WRITE, 8'hFF, 1'b1, SDA_RAND);
    issue_cmd(MODE_WAIT, 8'h00, 1'b0, SDA_HIGH);
    issue_cmd(MODE_START, 8'h00, 1'b0, SDA_RAND);
    issue_cmd(MODE_WRITE, 8'hA5, 1'b0, SDA_RAND);
    issue_cmd(MODE_WAIT, 8'h00, 1'b0, SDA_RAND);
    issue_cmd(MODE_READ, 8'h00, 1'b1, SDA_HIGH);
    issue_cmd(MODE_READ, 8'hFF, 1'b1, SDA_LOW);
    issue_cmd(MODE_READ, 8'h00, 1'b0, SDA_RAND);
    issue_cmd(MODE_STOP, 8'h00, 1'b0, SDA_RAND);
    idle_ticks(4);

    random_phase(16'd1, 8'd1, 100);
    random_phase(16'd0, 8'd0, 60);
    random_phase(16'd2, 8'd4, 80);

    // longest acknowledge wait, no idling on either side
    set_idling(1'b0);
    random_phase(16'd1, 8'd255, 30);
    issue_cmd(MODE_WAIT, 8'h00, 1'b0, SDA_HIGH);
    set_idling(1'b1);

    random_phase(16'($urandom_range(1, 3)), 8'($urandom_range(1, 8)), 60);

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
